// ----- src/imp_pkg.sv -----
// ----------------------------------------------------------------------------
// imp_pkg: shared types and constants for the integer matrix power block
// Field widths, register indexes, status codes and the control struct that
// travels from the sequencer to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package imp_pkg;

  // default largest matrix side
  localparam int MaxDimDef = 8;

  // fixed field widths
  localparam int DataW   = 32;
  localparam int IdxW    = 6;
  localparam int StatusW = 2;
  localparam int LoadW   = 7;
  localparam int DimW    = 4;
  localparam int ExpW    = 8;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgDim = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgExp = 2'd1;

  // register reset values
  localparam logic [DimW-1:0] DimReset = 4'd2;
  localparam logic [ExpW-1:0] ExpReset = 8'd3;

  // result status codes
  localparam logic [StatusW-1:0] StComputed = 2'd0;
  localparam logic [StatusW-1:0] StNone     = 2'd1;
  localparam logic [StatusW-1:0] StCopied   = 2'd2;

  // per-cycle control for one multiply-accumulate beat
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ----- src/imp_mac.sv -----
// ----------------------------------------------------------------------------
// imp_mac: shared multiply-accumulate unit
// Multiplies the two registered operands, accumulates over one dot product
// and hands the finished sum to the product store.
// ----------------------------------------------------------------------------
module imp_mac #(
  parameter int AW = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  imp_pkg::mac_ctl_t        ctl_i,
  input  logic [AW-1:0]            oaddr_i,
  input  logic [imp_pkg::DataW-1:0] lhs_i,
  input  logic [imp_pkg::DataW-1:0] rhs_i,
  output logic                     wr_en_o,
  output logic [AW-1:0]            wr_addr_o,
  output logic [imp_pkg::DataW-1:0] wr_data_o
);
  import imp_pkg::*;

  mac_ctl_t          s1_ctl_q, s2_ctl_q;
  logic [AW-1:0]     s1_addr_q, s2_addr_q;
  logic [DataW-1:0]  prod_q;
  logic [DataW-1:0]  acc_q;
  logic [DataW-1:0]  sum_d;
  logic [DataW-1:0]  mul_lo;

  // low word of the product, same for signed and unsigned operands
  assign mul_lo = lhs_i * rhs_i;

  // control tags follow the operands through the two stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
      s2_ctl_q <= '0;
    end else begin
      s1_ctl_q <= ctl_i;
      s2_ctl_q <= s1_ctl_q;
    end
  end

  // multiply stage and address tags
  always_ff @(posedge clk_i) begin
    s1_addr_q <= oaddr_i;
    s2_addr_q <= s1_addr_q;
    prod_q    <= mul_lo;
  end

  // accumulate, restart on the first term of each dot product
  assign sum_d = s2_ctl_q.first ? prod_q : acc_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (s2_ctl_q.vld) begin
      acc_q <= sum_d;
    end
  end

  assign wr_en_o   = s2_ctl_q.vld & s2_ctl_q.last;
  assign wr_addr_o = s2_addr_q;
  assign wr_data_o = sum_d;

endmodule

// ----- src/integer_matrix_power_top.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_power_top: square integer matrix raised to a power
// Loads a matrix element by element, multiplies it up on one shared
// multiply-accumulate unit and streams the result out in row-major order.
// ----------------------------------------------------------------------------
// Usage
//   Input beats: element_value_i is taken at an edge with start_i high and
//   busy_o low, row-major. The beat that completes dim*dim elements starts a
//   run. Other beats only store and give no result.
//   Config: cfg_index_i / cfg_data_i written when cfg_valid_i and cfg_ready_o
//   are high; index 0 is matrix_dim, index 1 is exponent. Write while idle.
//   Results: one beat per cycle while result_valid_o is high, last_o on the
//   final one. The receiver cannot stall; beats simply appear.
//   Timing: power 0 answers with one beat the cycle after the load beat.
//   Power 1 streams the loaded matrix, dim*dim beats, via the emit and
//   output registers. Otherwise each of the (power-1) products runs one
//   multiply-accumulate per cycle through the shared 32x32 multiplier and
//   its two pipeline stages, then drains; the dim*dim result beats follow
//   via the emit and output registers. busy_o rises after the completing beat
//   of a power 1 or higher run and falls in the cycle the last beat goes out.
//   Reset clears the sequencer, the load count and the registers to dim 2,
//   power 3; the stores hold no reset value and need no clearing pass.
// ----------------------------------------------------------------------------
module integer_matrix_power_top #(
  parameter int MAX_DIM = imp_pkg::MaxDimDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [imp_pkg::DataW-1:0] element_value_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [imp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [imp_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          result_valid_o,
  output logic [imp_pkg::StatusW-1:0]   status_o,
  output logic [imp_pkg::IdxW-1:0]      element_index_o,
  output logic signed [imp_pkg::DataW-1:0] result_value_o,
  output logic                          last_o
);
  import imp_pkg::*;

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int NW    = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e            state_q;
  logic [DimW-1:0]   dim_q;
  logic [ExpW-1:0]   exp_q;
  logic [LoadW-1:0]  lc_q;
  logic [LoadW-1:0]  lc_next;

  // run state
  logic [DW-1:0]     dm1_q, r_q, c_q, k_q;
  logic [AW-1:0]     d_aw_q, nm1_q;
  logic [AW-1:0]     la_q, ra_q, oa_q, row_base_q, e_q;
  logic [ExpW-1:0]   mul_left_q;
  logic              dst_q, right_src_q, copy_q, drain_q;

  // emit stage
  logic              e1_vld_q, e1_last_q, e1_copy_q;
  logic [AW-1:0]     e1_idx_q;

  // output registers
  logic              out_vld_q, out_last_q;
  logic [StatusW-1:0] out_status_q;
  logic [IdxW-1:0]   out_idx_q;
  logic [DataW-1:0]  out_val_q;

  // effective dimension of the incoming beat
  logic [DW-1:0]     d_eff;
  logic [NW-1:0]     n_eff;
  logic              accept, complete;

  // memories
  logic [DataW-1:0]  src_mem  [Depth];
  logic [DataW-1:0]  prod_mem [2*Depth];
  logic [DataW-1:0]  src_a_q, src_b_q, prod_rd_q;
  logic [AW-1:0]     src_b_addr;
  logic [AW:0]       prod_raddr;
  logic              src_we;

  // mac interface
  mac_ctl_t          mac_ctl;
  logic              mac_we;
  logic [AW-1:0]     mac_waddr;
  logic [DataW-1:0]  mac_wdata;
  logic [DataW-1:0]  rhs;

  always_comb begin
    if (dim_q == '0) begin
      d_eff = DW'(1);
    end else if (int'(dim_q) > MAX_DIM) begin
      d_eff = DW'(MAX_DIM);
    end else begin
      d_eff = DW'(dim_q);
    end
  end

  assign n_eff    = NW'(d_eff) * NW'(d_eff);
  assign busy_o   = (state_q != S_IDLE) || e1_vld_q;
  assign cfg_ready_o = ~busy_o;
  assign accept   = start_i & ~busy_o;
  assign lc_next  = lc_q + 1'b1;
  assign complete = int'(lc_next) >= int'(n_eff);
  assign src_we   = accept && (int'(lc_q) < Depth);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DimReset;
      exp_q <= ExpReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgDim:  dim_q <= cfg_data_i[DimW-1:0];
        CfgExp:  exp_q <= cfg_data_i[ExpW-1:0];
        default: ;
      endcase
    end
  end

  // source store, two registered read ports
  assign src_b_addr = (state_q == S_MUL) ? ra_q : e_q;

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[AW'(lc_q)] <= element_value_i;
    end
    src_a_q <= src_mem[la_q];
    src_b_q <= src_mem[src_b_addr];
  end

  // product store, two banks used in turn
  assign prod_raddr = (state_q == S_MUL) ? {~dst_q, ra_q} : {dst_q, e_q};

  always_ff @(posedge clk_i) begin
    if (mac_we) begin
      prod_mem[{dst_q, mac_waddr}] <= mac_wdata;
    end
    prod_rd_q <= prod_mem[prod_raddr];
  end

  // shared multiply-accumulate unit
  assign mac_ctl.vld   = (state_q == S_MUL);
  assign mac_ctl.first = (k_q == '0);
  assign mac_ctl.last  = (k_q == dm1_q);
  assign rhs = right_src_q ? src_b_q : prod_rd_q;

  imp_mac #(
    .AW(AW)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .oaddr_i   (oa_q),
    .lhs_i     (src_a_q),
    .rhs_i     (rhs),
    .wr_en_o   (mac_we),
    .wr_addr_o (mac_waddr),
    .wr_data_o (mac_wdata)
  );

  // sequencer, load count and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lc_q         <= '0;
      dm1_q        <= '0;
      r_q          <= '0;
      c_q          <= '0;
      k_q          <= '0;
      d_aw_q       <= '0;
      nm1_q        <= '0;
      la_q         <= '0;
      ra_q         <= '0;
      oa_q         <= '0;
      row_base_q   <= '0;
      e_q          <= '0;
      mul_left_q   <= '0;
      dst_q        <= 1'b0;
      right_src_q  <= 1'b1;
      copy_q       <= 1'b0;
      drain_q      <= 1'b0;
      e1_vld_q     <= 1'b0;
      e1_last_q    <= 1'b0;
      e1_copy_q    <= 1'b0;
      e1_idx_q     <= '0;
      out_vld_q    <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= StComputed;
      out_idx_q    <= '0;
      out_val_q    <= '0;
    end else begin
      // output stage: power-zero beat, else the emit tags
      if (accept && complete && (exp_q == '0)) begin
        out_vld_q    <= 1'b1;
        out_last_q   <= 1'b1;
        out_status_q <= StNone;
        out_idx_q    <= '0;
        out_val_q    <= '0;
      end else begin
        out_vld_q    <= e1_vld_q;
        out_last_q   <= e1_vld_q & e1_last_q;
        out_status_q <= e1_copy_q ? StCopied : StComputed;
        out_idx_q    <= IdxW'(e1_idx_q);
        out_val_q    <= e1_copy_q ? src_b_q : prod_rd_q;
      end
      e1_vld_q <= (state_q == S_EMIT);

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            lc_q <= complete ? '0 : lc_next;
            if (complete) begin
              dm1_q       <= d_eff - 1'b1;
              d_aw_q      <= AW'(d_eff);
              nm1_q       <= AW'(n_eff - 1'b1);
              r_q         <= '0;
              c_q         <= '0;
              k_q         <= '0;
              la_q        <= '0;
              ra_q        <= '0;
              oa_q        <= '0;
              row_base_q  <= '0;
              e_q         <= '0;
              dst_q       <= 1'b0;
              right_src_q <= 1'b1;
              mul_left_q  <= exp_q - 1'b1;
              // power zero stays idle, its beat comes from the output stage
              if (exp_q == ExpW'(1)) begin
                copy_q  <= 1'b1;
                state_q <= S_EMIT;
              end else if (exp_q != '0) begin
                copy_q  <= 1'b0;
                state_q <= S_MUL;
              end
            end
          end
        end

        S_MUL: begin
          // walk k inside c inside r, one beat per cycle
          if (k_q == dm1_q) begin
            k_q  <= '0;
            oa_q <= oa_q + 1'b1;
            if (c_q == dm1_q) begin
              c_q <= '0;
              if (r_q == dm1_q) begin
                drain_q <= 1'b0;
                state_q <= S_DRAIN;
              end else begin
                r_q        <= r_q + 1'b1;
                row_base_q <= row_base_q + d_aw_q;
                la_q       <= row_base_q + d_aw_q;
                ra_q       <= '0;
              end
            end else begin
              c_q  <= c_q + 1'b1;
              la_q <= row_base_q;
              ra_q <= AW'(c_q) + 1'b1;
            end
          end else begin
            k_q  <= k_q + 1'b1;
            la_q <= la_q + 1'b1;
            ra_q <= ra_q + d_aw_q;
          end
        end

        S_DRAIN: begin
          // let the last sum reach the store before it is read back
          drain_q <= 1'b1;
          if (drain_q) begin
            if (mul_left_q == ExpW'(1)) begin
              e_q     <= '0;
              state_q <= S_EMIT;
            end else begin
              mul_left_q  <= mul_left_q - 1'b1;
              dst_q       <= ~dst_q;
              right_src_q <= 1'b0;
              r_q         <= '0;
              c_q         <= '0;
              k_q         <= '0;
              la_q        <= '0;
              ra_q        <= '0;
              oa_q        <= '0;
              row_base_q  <= '0;
              state_q     <= S_MUL;
            end
          end
        end

        S_EMIT: begin
          e1_idx_q  <= e_q;
          e1_last_q <= (e_q == nm1_q);
          e1_copy_q <= copy_q;
          if (e_q == nm1_q) begin
            state_q <= S_IDLE;
          end else begin
            e_q <= e_q + 1'b1;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o  = out_vld_q;
  assign status_o        = out_status_q;
  assign element_index_o = out_idx_q;
  assign result_value_o  = out_val_q;
  assign last_o          = out_last_q;

endmodule

// ----- src/imp_checker.sv -----
// ----------------------------------------------------------------------------
// imp_checker: port-level checks for the integer matrix power block
// Watches the result stream and the busy flag over time.
// ----------------------------------------------------------------------------
module imp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          busy_o,
  input logic                          result_valid_o,
  input logic [imp_pkg::StatusW-1:0]   status_o,
  input logic [imp_pkg::IdxW-1:0]      element_index_o,
  input logic                          last_o
);
  import imp_pkg::*;

  // a run streams without gaps
  a_stream_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("gap inside a result run");

  // row-major positions count up by one
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=>
      element_index_o == $past(element_index_o) + 6'd1)
    else $error("result index did not advance by one");

  // one status for the whole run
  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> status_o == $past(status_o))
    else $error("status changed inside a run");

  // no new element taken while a run is still streaming
  a_busy_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("block idle while results remain");

  // power zero gives exactly one beat at position zero
  a_none_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == StNone |-> last_o && element_index_o == '0)
    else $error("no-calculation result not a single beat");

endmodule

bind integer_matrix_power_top imp_checker u_imp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .busy_o          (busy_o),
  .result_valid_o  (result_valid_o),
  .status_o        (status_o),
  .element_index_o (element_index_o),
  .last_o          (last_o)
);
